>>> sv/altimeter_zero_and_apogee_detect_top_macros.svh
// Assertion helpers shared by the RTL of the altimeter block.
`ifndef ALTIMETER_ZERO_AND_APOGEE_DETECT_TOP_MACROS_SVH
`define ALTIMETER_ZERO_AND_APOGEE_DETECT_TOP_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define AZAD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define AZAD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/azad_pkg.sv
`default_nettype none
package azad_pkg;

   localparam int ALT_WIDTH  = 24;
   localparam int REG_WIDTH  = 24;
   localparam int DROP_WIDTH = 23;
   localparam int CSR_IDX_W  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_APOGEE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DROP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_HIGH = 2'd3;

   // register reset values
   localparam logic signed [REG_WIDTH-1:0] MIN_APOGEE_RST  = 24'sd0;
   localparam logic [DROP_WIDTH-1:0]       MIN_DROP_RST    = 23'd100;
   localparam logic signed [REG_WIDTH-1:0] OFFSET_LOW_RST  = 24'sd10000;
   localparam logic signed [REG_WIDTH-1:0] OFFSET_HIGH_RST = 24'sd50000;

   typedef enum logic [1:0] {
      CAL_PENDING  = 2'd0,
      CAL_OK       = 2'd1,
      CAL_RANGE    = 2'd2,
      CAL_NO_VALID = 2'd3
   } cal_status_type;

   typedef enum logic {
      PHASE_CAL    = 1'b0,
      PHASE_FLIGHT = 1'b1
   } phase_type;

   typedef struct packed {
      logic                        sample_valid;
      logic signed [ALT_WIDTH-1:0] altitude_raw;
   } req_type;

   typedef struct packed {
      phase_type                   phase;
      cal_status_type              cal_status;
      logic signed [ALT_WIDTH-1:0] altitude_corrected;
      logic signed [ALT_WIDTH-1:0] peak_altitude;
      logic                        apogee_detected;
      logic                        apogee_now;
   } rsp_type;

endpackage
`default_nettype wire

>>> sv/altimeter_zero_and_apogee_detect_top.sv
`default_nettype none
// Channel    Ports                         Moves
// ---------  ----------------------------  -----------------------------------------
// request    req_valid/req_ready/req_data  one altitude sample per transaction
// response   rsp_valid/rsp_ready/rsp_data  one result per request transaction
// csr        csr_we/csr_index/csr_wdata    register write, taken on the enable edge
//
// Calibration sample: accepted, accumulated, then written out to the result register.
// Last calibration sample: accumulate, then the restoring divider, which produces
//    one quotient bit per cycle of the ground offset mean, then range check, write out.
// Flight sample: offset subtract and saturate, peak/apogee, write out.
// Reset is synchronous, active high; no clearing pass. req_ready is low while a sample
//    is in work; a finished result waits in the response register, so a stalled
//    response holds the block only when a second result is ready to be written.
`include "altimeter_zero_and_apogee_detect_top_macros.svh"
module altimeter_zero_and_apogee_detect_top #(
   parameter int CAL_SAMPLES = 500
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire azad_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output azad_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [azad_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [azad_pkg::REG_WIDTH-1:0]  csr_wdata
);

   localparam int AW    = azad_pkg::ALT_WIDTH;
   localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
   // sum of CAL_SAMPLES signed samples
   localparam int SUM_W = AW + CNT_W;
   localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES);
   localparam logic signed [AW-1:0] ALT_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] ALT_MIN = {1'b1, {(AW-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAL,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_CHECK,
      ST_FLY_ALT,
      ST_FLY_APO,
      ST_OUT
   } state_type;

   // configuration registers
   logic signed [azad_pkg::REG_WIDTH-1:0] min_apogee_ff, offset_low_ff, offset_high_ff;
   logic [azad_pkg::DROP_WIDTH-1:0]       min_drop_ff;

   state_type                state_ff, state_in;
   logic                     valid_ff, valid_in;
   logic signed [AW-1:0]     raw_ff, raw_in;
   logic [CNT_W-1:0]         attempt_ff, attempt_in;
   logic [CNT_W-1:0]         vcount_ff, vcount_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [AW-1:0]     offset_ff, offset_in;
   azad_pkg::cal_status_type cal_ff, cal_in;
   logic signed [AW-1:0]     last_alt_ff, last_alt_in;
   logic signed [AW-1:0]     peak_ff, peak_in;
   logic                     climbing_ff, climbing_in;
   logic                     apogee_ff, apogee_in;
   logic                     now_ff, now_in;
   logic                     flight_ff, flight_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   azad_pkg::rsp_type        rsp_ff, rsp_in;

   // divider for the ground offset mean
   logic                    div_start;
   logic [SUM_W-1:0]        div_dividend;
   logic                    div_done;
   logic [SUM_W-1:0]        div_quotient;
   logic [AW-1:0]           quo_mag;

   logic signed [AW:0]      alt_diff;
   logic signed [AW:0]      drop_sum;

   assign div_dividend = sum_ff[SUM_W-1] ? (-sum_ff) : sum_ff;
   assign quo_mag      = div_quotient[AW-1:0];
   assign alt_diff     = {raw_ff[AW-1], raw_ff} - {offset_ff[AW-1], offset_ff};
   assign drop_sum     = {last_alt_ff[AW-1], last_alt_ff}
                         + (AW+1)'($signed({1'b0, min_drop_ff}));

   azad_div #(
      .DVD_W (SUM_W),
      .DVR_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (vcount_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      raw_in       = raw_ff;
      attempt_in   = attempt_ff;
      vcount_in    = vcount_ff;
      sum_in       = sum_ff;
      offset_in    = offset_ff;
      cal_in       = cal_ff;
      last_alt_in  = last_alt_ff;
      peak_in      = peak_ff;
      climbing_in  = climbing_ff;
      apogee_in    = apogee_ff;
      now_in       = now_ff;
      flight_in    = flight_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               valid_in  = req_data.sample_valid;
               raw_in    = req_data.altitude_raw;
               now_in    = 1'b0;
               flight_in = (cal_ff != azad_pkg::CAL_PENDING);
               state_in  = (cal_ff == azad_pkg::CAL_PENDING) ? ST_CAL : ST_FLY_ALT;
            end
         end
         ST_CAL: begin
            attempt_in = attempt_ff + 1'b1;
            if (valid_ff) begin
               sum_in    = sum_ff + SUM_W'(raw_ff);
               vcount_in = vcount_ff + 1'b1;
            end
            state_in = ST_OUT;
            if (attempt_in >= CAL_LAST) begin
               if (vcount_in == '0) begin
                  cal_in = azad_pkg::CAL_NO_VALID;
               end else begin
                  state_in = ST_DIV_LOAD;
               end
            end
         end
         ST_DIV_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               // mean truncates toward zero: sign applied after the unsigned divide
               offset_in = sum_ff[SUM_W-1] ? (-$signed(quo_mag)) : $signed(quo_mag);
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (offset_ff > offset_low_ff && offset_ff < offset_high_ff) begin
               cal_in = azad_pkg::CAL_OK;
            end else begin
               cal_in = azad_pkg::CAL_RANGE;
            end
            state_in = ST_OUT;
         end
         ST_FLY_ALT: begin
            // invalid sample keeps the previous corrected altitude
            if (valid_ff) begin
               if (alt_diff[AW] != alt_diff[AW-1]) begin
                  last_alt_in = alt_diff[AW] ? ALT_MIN : ALT_MAX;
               end else begin
                  last_alt_in = alt_diff[AW-1:0];
               end
            end
            state_in = ST_FLY_APO;
         end
         ST_FLY_APO: begin
            if (last_alt_ff > peak_ff) begin
               peak_in = last_alt_ff;
            end
            // a new peak can never be more than the drop below itself
            if (last_alt_ff > min_apogee_ff && drop_sum < $signed({peak_ff[AW-1], peak_ff})
                && climbing_ff) begin
               apogee_in   = 1'b1;
               climbing_in = 1'b0;
               now_in      = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.phase       = flight_ff ? azad_pkg::PHASE_FLIGHT : azad_pkg::PHASE_CAL;
               rsp_in.cal_status  = cal_ff;
               rsp_in.altitude_corrected = flight_ff ? last_alt_ff : '0;
               rsp_in.peak_altitude      = flight_ff ? peak_ff : '0;
               rsp_in.apogee_detected    = flight_ff && apogee_ff;
               rsp_in.apogee_now         = flight_ff && now_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         attempt_ff     <= '0;
         vcount_ff      <= '0;
         sum_ff         <= '0;
         offset_ff      <= '0;
         cal_ff         <= azad_pkg::CAL_PENDING;
         last_alt_ff    <= '0;
         peak_ff        <= '0;
         climbing_ff    <= 1'b1;
         apogee_ff      <= 1'b0;
         now_ff         <= 1'b0;
         flight_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         min_apogee_ff  <= azad_pkg::MIN_APOGEE_RST;
         min_drop_ff    <= azad_pkg::MIN_DROP_RST;
         offset_low_ff  <= azad_pkg::OFFSET_LOW_RST;
         offset_high_ff <= azad_pkg::OFFSET_HIGH_RST;
      end else begin
         state_ff     <= state_in;
         attempt_ff   <= attempt_in;
         vcount_ff    <= vcount_in;
         sum_ff       <= sum_in;
         offset_ff    <= offset_in;
         cal_ff       <= cal_in;
         last_alt_ff  <= last_alt_in;
         peak_ff      <= peak_in;
         climbing_ff  <= climbing_in;
         apogee_ff    <= apogee_in;
         now_ff       <= now_in;
         flight_ff    <= flight_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               azad_pkg::CSR_MIN_APOGEE:  min_apogee_ff  <= csr_wdata;
               azad_pkg::CSR_MIN_DROP:    min_drop_ff    <= csr_wdata[azad_pkg::DROP_WIDTH-1:0];
               azad_pkg::CSR_OFFSET_LOW:  offset_low_ff  <= csr_wdata;
               azad_pkg::CSR_OFFSET_HIGH: offset_high_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      valid_ff <= valid_in;
      raw_ff   <= raw_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `AZAD_ASSERT_NXT(a_apogee_sticky, apogee_ff, apogee_ff, "apogee latch cleared")
   `AZAD_ASSERT_IMP(a_apogee_stops_climb, apogee_ff, !climbing_ff,
                    "still climbing after apogee")
   `AZAD_ASSERT_NXT(a_cal_sticky, cal_ff != azad_pkg::CAL_PENDING,
                    cal_ff != azad_pkg::CAL_PENDING, "calibration result reverted to pending")
   `AZAD_ASSERT_IMP(a_peak_nonneg, 1'b1, !peak_ff[AW-1], "peak altitude below zero")
   `AZAD_ASSERT_IMP(a_div_done_waits, div_done, state_ff == ST_DIV_WAIT,
                    "divider finished outside the divide wait")

endmodule
`default_nettype wire

>>> sv/azad_div.sv
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module azad_div #(
   parameter int DVD_W = 33,
   parameter int DVR_W = 9
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVR_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [DVR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVR_W-1:0] dvr_ff, dvr_in;

   logic [DVR_W:0]   shifted;
   logic [DVR_W+1:0] trial;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvr_in  = dvr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvr_in  = divisor;
      end else if (busy_ff) begin
         // trial subtract: negative result means restore
         if (trial[DVR_W+1]) begin
            rem_in = shifted[DVR_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DVR_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvr_ff <= dvr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> dv/altimeter_result_checker.sv
// Watches the sample, result and register ports, keeps its own copy of the
// zeroing/apogee state and compares every result transaction in order.
module altimeter_result_checker
   import azad_pkg::*;
#(
   parameter int CAL_SAMPLES = 500
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [REG_WIDTH-1:0]   csr_wdata,
   output int                     mismatches,
   output int                     outstanding
);

   logic signed [REG_WIDTH-1:0] apogee_floor;
   logic [DROP_WIDTH-1:0]       drop_margin;
   logic signed [REG_WIDTH-1:0] offset_lo;
   logic signed [REG_WIDTH-1:0] offset_hi;

   int             cal_attempts;
   int             cal_valid;
   longint         cal_sum;
   longint         zero_offset;
   cal_status_type cal_state;
   longint         held_alt;
   longint         peak_alt;
   bit             climbing;
   bit             apogee_seen;

   rsp_type        expected_q[$];
   int             result_idx;

   function automatic longint clamp_alt(input longint v);
      longint hi_lim;
      hi_lim = (longint'(1) <<< (ALT_WIDTH - 1)) - 1;
      if (v > hi_lim) return hi_lim;
      if (v < -hi_lim - 1) return -hi_lim - 1;
      return v;
   endfunction

   function automatic rsp_type predict_sample(input req_type item);
      rsp_type r;
      longint  raw;
      longint  mag;
      bit      now;
      r = '0;
      now = 1'b0;
      raw = $signed(item.altitude_raw);
      if (cal_state == CAL_PENDING) begin
         cal_attempts++;
         if (item.sample_valid) begin
            cal_sum += raw;
            cal_valid++;
         end
         if (cal_attempts >= CAL_SAMPLES) begin
            if (cal_valid == 0) begin
               cal_state = CAL_NO_VALID;
            end else begin
               // mean truncated toward zero
               mag = (cal_sum < 0) ? -cal_sum : cal_sum;
               zero_offset = (cal_sum < 0) ? -(mag / cal_valid) : mag / cal_valid;
               cal_state = (zero_offset > offset_lo && zero_offset < offset_hi) ?
                           CAL_OK : CAL_RANGE;
            end
         end
         r.phase = PHASE_CAL;
         r.cal_status = cal_state;
         return r;
      end
      if (item.sample_valid) held_alt = clamp_alt(raw - zero_offset);
      if (held_alt > peak_alt) peak_alt = held_alt;
      if (held_alt > apogee_floor && held_alt + longint'(drop_margin) < peak_alt &&
          climbing) begin
         apogee_seen = 1'b1;
         climbing = 1'b0;
         now = 1'b1;
      end
      r.phase = PHASE_FLIGHT;
      r.cal_status = cal_state;
      r.altitude_corrected = held_alt[ALT_WIDTH-1:0];
      r.peak_altitude = peak_alt[ALT_WIDTH-1:0];
      r.apogee_detected = apogee_seen;
      r.apogee_now = now;
      return r;
   endfunction

   task automatic note_field(input string field, input logic [ALT_WIDTH-1:0] want,
                             input logic [ALT_WIDTH-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s, result %0d: expected %0d, got %0d",
                     field, result_idx, $signed(want), $signed(got));
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         apogee_floor = MIN_APOGEE_RST;
         drop_margin  = MIN_DROP_RST;
         offset_lo    = OFFSET_LOW_RST;
         offset_hi    = OFFSET_HIGH_RST;
         cal_attempts = 0;
         cal_valid    = 0;
         cal_sum      = 0;
         zero_offset  = 0;
         cal_state    = CAL_PENDING;
         held_alt     = 0;
         peak_alt     = 0;
         climbing     = 1'b1;
         apogee_seen  = 1'b0;
         expected_q.delete();
         result_idx   = 0;
         mismatches   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_APOGEE:  apogee_floor = csr_wdata;
               CSR_MIN_DROP:    drop_margin  = csr_wdata[DROP_WIDTH-1:0];
               CSR_OFFSET_LOW:  offset_lo    = csr_wdata;
               CSR_OFFSET_HIGH: offset_hi    = csr_wdata;
               default: ;
            endcase
         end
         // results first: one accepted at this edge cannot stem from a sample
         // accepted at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d arrived with nothing outstanding", result_idx);
            end else begin
               want = expected_q.pop_front();
               note_field("phase", want.phase, rsp_data.phase);
               note_field("cal_status", want.cal_status, rsp_data.cal_status);
               note_field("altitude_corrected", want.altitude_corrected,
                          rsp_data.altitude_corrected);
               note_field("peak_altitude", want.peak_altitude, rsp_data.peak_altitude);
               note_field("apogee_detected", want.apogee_detected,
                          rsp_data.apogee_detected);
               note_field("apogee_now", want.apogee_now, rsp_data.apogee_now);
            end
            result_idx++;
         end
         if (req_valid && req_ready) expected_q.push_back(predict_sample(req_data));
      end
      outstanding = expected_q.size();
   end

endmodule

>>> dv/tb_altimeter_zero_and_apogee_detect_top.sv
// Stimulus and verdict for the altimeter zeroing / apogee block. The checker
// beside the block does all prediction and comparison.
module tb_altimeter_zero_and_apogee_detect_top;
   import azad_pkg::*;

   localparam int CAL_COUNT   = 500;
   localparam int CYCLE_LIMIT = 400000;

   // ways the one calibration of a run can end
   localparam int PLAN_IN_RANGE = 0;
   localparam int PLAN_ON_BOUND = 1;
   localparam int PLAN_FAR      = 2;
   localparam int PLAN_NO_VALID = 3;

   localparam logic signed [ALT_WIDTH-1:0] ALT_MAX = {1'b0, {(ALT_WIDTH-1){1'b1}}};
   localparam logic signed [ALT_WIDTH-1:0] ALT_MIN = {1'b1, {(ALT_WIDTH-1){1'b0}}};
   localparam int REG_MAX  = (1 << (REG_WIDTH - 1)) - 1;
   localparam int REG_MIN  = -(1 << (REG_WIDTH - 1));
   localparam int DROP_MAX = (1 << DROP_WIDTH) - 1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MIN_APOGEE;
   logic [REG_WIDTH-1:0] csr_wdata = '0;

   int mismatches;
   int outstanding;

   int send_idle = 0;   // per cent of cycles the sample side holds back
   int recv_idle = 0;   // per cent of cycles the result side stalls
   int sent      = 0;   // sample transactions accepted
   int received  = 0;   // result transactions accepted
   int cycles    = 0;
   int base_alt  = 0;   // ground level the raw samples are built around

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   altimeter_zero_and_apogee_detect_top #(.CAL_SAMPLES(CAL_COUNT)) uut (.*);

   altimeter_result_checker #(.CAL_SAMPLES(CAL_COUNT)) results_watch (.*);

   // Result side: random stalls, transaction count and the watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (rsp_valid && rsp_ready) received <= received + 1;
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // One sample transaction. Valid stays up across back-to-back samples and
   // is only dropped when a gap is chosen, so it never sees two updates in
   // one step.
   task automatic push_sample(input logic valid_bit, input logic signed [ALT_WIDTH-1:0] alt);
      int gap;
      req_data  <= {valid_bit, alt};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every result is back, so the block is idle
   // before registers change.
   task automatic settle();
      req_valid <= 1'b0;
      while (received != sent) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // All four registers in index order, enable held high across the burst.
   // The drop register is narrower than the port; its spare top bit is
   // randomised to show it is discarded.
   task automatic program_regs(input int floor_alt, input int drop, input int lo, input int hi);
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_APOGEE;
      csr_wdata <= REG_WIDTH'(floor_alt);
      @(posedge clock);
      csr_index <= CSR_MIN_DROP;
      csr_wdata <= {1'($urandom_range(0, 1)), DROP_WIDTH'(drop)};
      @(posedge clock);
      csr_index <= CSR_OFFSET_LOW;
      csr_wdata <= REG_WIDTH'(lo);
      @(posedge clock);
      csr_index <= CSR_OFFSET_HIGH;
      csr_wdata <= REG_WIDTH'(hi);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // The calibration window: failed reads at the range extremes and at zero first
   // (they must not enter the mean), then samples around base_alt shaped by the plan.
   task automatic calibrate_ground(input int plan);
      int i;
      push_sample(1'b0, ALT_MAX);
      push_sample(1'b0, ALT_MIN);
      push_sample(1'b0, '0);
      for (i = 3; i < CAL_COUNT; i++) begin
         case (plan)
            PLAN_NO_VALID: push_sample(1'b0, ALT_WIDTH'($urandom()));
            // every good sample exactly on the bound: mean equals it
            PLAN_ON_BOUND: push_sample(i == 3 || $urandom_range(0, 3) != 0,
                                       ALT_WIDTH'(base_alt));
            default:       push_sample(i == 3 || $urandom_range(0, 9) != 0,
                                       ALT_WIDTH'(base_alt + int'($urandom_range(0, 100)) - 50));
         endcase
      end
   endtask

   // Flight: climb and descent legs of random length and rate around
   // base_alt, rising legs longer so the track drifts upward and apogee gets
   // a chance. One read in ten fails. With noise on, a tenth of the
   // samples are arbitrary values over the whole field.
   task automatic fly_profile(input int count, input bit noisy);
      int i;
      int h;
      int leg_left;
      int step;
      bit rising;
      h = 0;
      leg_left = 0;
      rising = 1'b0;
      for (i = 0; i < count; i++) begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            push_sample(1'($urandom_range(0, 1)), ALT_WIDTH'($urandom()));
         end else begin
            if (leg_left == 0) begin
               rising = !rising;
               leg_left = rising ? $urandom_range(10, 40) : $urandom_range(5, 25);
            end
            leg_left--;
            step = $urandom_range(0, 400);
            h = rising ? h + step : h - step;
            if ($urandom_range(0, 9) == 0)
               push_sample(1'b0, ALT_WIDTH'($urandom()));
            else
               push_sample(1'b1, ALT_WIDTH'(base_alt + h));
         end
      end
   endtask

   initial begin
      int plan;
      int lo_bound;
      int hi_bound;

      // first pass: sender idles little, receiver a lot
      send_idle = 26;
      recv_idle = 68;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Only one calibration per run, so the seed picks how it ends.
      plan = $urandom_range(0, 3);
      case (plan)
         PLAN_IN_RANGE: begin
            // either sign; a negative sum checks truncation toward zero
            base_alt = int'($urandom_range(0, 8000000)) - 4000000;
            lo_bound = base_alt - int'($urandom_range(300, 5000));
            hi_bound = base_alt + int'($urandom_range(300, 5000));
         end
         PLAN_ON_BOUND: begin
            // both bounds are exclusive, so a mean sitting on one is out
            base_alt = int'($urandom_range(0, 8000000)) - 4000000;
            if ($urandom_range(0, 1)) begin
               lo_bound = base_alt;
               hi_bound = REG_MAX;
            end else begin
               lo_bound = REG_MIN;
               hi_bound = base_alt;
            end
         end
         PLAN_FAR: begin
            // offset far out of range but still used: flight extremes saturate
            base_alt = $urandom_range(0, 1) ? 8000000 : -8000000;
            lo_bound = OFFSET_LOW_RST;
            hi_bound = OFFSET_HIGH_RST;
         end
         default: begin
            base_alt = 0;
            lo_bound = int'($urandom_range(0, 20000)) - 10000;
            hi_bound = lo_bound + int'($urandom_range(1, 20000));
         end
      endcase

      program_regs($urandom_range(0, 2000), $urandom_range(50, 500), lo_bound, hi_bound);
      calibrate_ground(plan);

      // first flight sample fails: the held altitude of zero is reported
      push_sample(1'b0, ALT_MIN);
      push_sample(1'b1, ALT_WIDTH'(base_alt));
      push_sample(1'b1, ALT_WIDTH'(base_alt + 1));
      fly_profile(147, 1'b0);
      settle();

      // second pass: roles swapped; lowest floor and no drop margin, so any
      // dip declares apogee if it has not come yet
      send_idle = 68;
      recv_idle = 26;
      program_regs(REG_MIN, 0, REG_MIN, REG_MAX);
      fly_profile(250, 1'b1);
      settle();

      // last pass: no idling; floor and drop at their maximum
      send_idle = 0;
      recv_idle = 0;
      program_regs(REG_MAX, DROP_MAX, int'($urandom_range(0, 20000)) - 10000,
                   int'($urandom_range(0, 20000)));
      push_sample(1'b1, ALT_MAX);
      push_sample(1'b1, ALT_MIN);
      push_sample(1'b1, '0);
      push_sample(1'b1, '1);
      push_sample(1'b0, ALT_MAX);
      push_sample(1'b1, ALT_WIDTH'(base_alt));
      fly_profile(244, 1'b1);
      settle();
      repeat (100) @(posedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
